FILE: rtl/velocity_density_converter_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the velocity/density converter
// Immediate-implication and next-cycle checks, clocked on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef VELOCITY_DENSITY_CONVERTER_UNIT_ASSERT_SVH
`define VELOCITY_DENSITY_CONVERTER_UNIT_ASSERT_SVH

// cond holds -> expr holds in the same cycle
`define VDC_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// cond holds -> expr holds in the next cycle
`define VDC_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

FILE: rtl/vdc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vdc_pkg
// Shared widths, codes and the per-stage payload type of the converter.
// ---------------------------------------------------------------------------
package vdc_pkg;

    localparam int VS_W  = 16;
    localparam int VP_W  = 18;
    localparam int RHO_W = 16;

    // Horner accumulator; covers the quartic at full-scale input for 8..20 frac bits
    localparam int ACC_W = 40;

    localparam int VP_MAX  = 262143;
    localparam int RHO_MAX = 65535;

    // (2*vs + 4) / 9 by reciprocal: floor(x * ceil(2^21/9) / 2^21), exact for x < 2^21
    localparam int                DIV9_X_W   = VS_W + 2;
    localparam int                DIV9_SHIFT = 21;
    localparam int                DIV9_Q_W   = 15;
    localparam logic [DIV9_X_W-1:0] DIV9_RECIP = 18'd233017;

    localparam logic [2:0] VP_MODE_POLY      = 3'd1;
    localparam logic [2:0] VP_MODE_RATIO_FIX = 3'd2;
    localparam logic [2:0] VP_MODE_RATIO_CFG = 3'd3;
    localparam logic [2:0] VP_MODE_LINEAR    = 3'd4;

    localparam logic [1:0] RHO_MODE_LINEAR = 2'd2;

    localparam logic [1:0] REG_VP_MODE    = 2'd0;
    localparam logic [1:0] REG_RHO_MODE   = 2'd1;
    localparam logic [1:0] REG_VPVS_RATIO = 2'd2;
    localparam logic [1:0] REG_DENS_OFS   = 2'd3;

    typedef struct packed {
        logic [VS_W-1:0]         vs;
        logic signed [ACC_W-1:0] vp;
        logic signed [ACC_W-1:0] rho;
    } lane_t;

endpackage

FILE: rtl/vdc_horner_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vdc_horner_step
// One registered Horner step: rho <- round(rho * vs) + coef; vp likewise when vp_mul_en, else passed through.
// ---------------------------------------------------------------------------
module vdc_horner_step #(
    parameter int FRAC_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  valid_in,
    input  vdc_pkg::lane_t                        lane_in,
    input  logic signed [vdc_pkg::ACC_W-1:0]      vp_coef,
    input  logic signed [vdc_pkg::ACC_W-1:0]      rho_coef,
    input  logic                                  vp_mul_en,
    output logic                                  valid_out,
    output vdc_pkg::lane_t                        lane_out
);

    localparam int PROD_W = vdc_pkg::ACC_W + vdc_pkg::VS_W + 1;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

    logic           valid_reg;
    vdc_pkg::lane_t lane_reg;
    vdc_pkg::lane_t lane_next;

    // Q.F product, rounded to nearest with ties away from zero
    function automatic logic signed [vdc_pkg::ACC_W-1:0] qmul(
        input logic signed [vdc_pkg::ACC_W-1:0] a,
        input logic [vdc_pkg::VS_W-1:0]         v
    );
        logic signed [PROD_W-1:0]         prod;
        logic [PROD_W-1:0]                mag;
        logic [PROD_W-1:0]                rnd;
        logic signed [vdc_pkg::ACC_W-1:0] res;
        prod = PROD_W'(a) * PROD_W'($signed({1'b0, v}));
        mag  = prod[PROD_W-1] ? $unsigned(-prod) : $unsigned(prod);
        rnd  = (mag + HALF) >> FRAC_BITS;
        res  = $signed(rnd[vdc_pkg::ACC_W-1:0]);
        return prod[PROD_W-1] ? -res : res;
    endfunction

    always_comb
    begin
        lane_next     = lane_in;
        lane_next.rho = qmul(lane_in.rho, lane_in.vs) + rho_coef;
        if (vp_mul_en)
        begin
            lane_next.vp = qmul(lane_in.vp, lane_in.vs) + vp_coef;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign valid_out = valid_reg;
    assign lane_out  = lane_reg;

endmodule

FILE: rtl/velocity_density_converter_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// velocity_density_converter_unit
// Shear velocity to compressional velocity and density, five-stage pipeline.
// ---------------------------------------------------------------------------
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+-----------
//  input    | in_valid, in_stall, shear_velocity        | sample in
//  output   | out_valid, out_stall, compressional_velocity, density | result out
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
//  One sample per cycle sustained while out_stall stays low. An input transfer passes
//  four Horner multiply-round-add stages, then a clamp/output register, to out_valid.
//  Each stage holds its own valid bit and loads when it is empty or its successor
//  moves, so bubbles close up and input keeps flowing while a result waits.
//  rst_n clears valid bits and restores the mode/ratio/offset registers.
//  Configuration is accepted every cycle (cfg_ready is tied high).
// ---------------------------------------------------------------------------
module velocity_density_converter_unit #(
    parameter int FRAC_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // sample input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [vdc_pkg::VS_W-1:0]       shear_velocity,
    // result output
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [vdc_pkg::VP_W-1:0]       compressional_velocity,
    output logic [vdc_pkg::RHO_W-1:0]      density,
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [15:0]                    cfg_data
);

    `include "velocity_density_converter_unit_assert.svh"

    localparam int ACC_W = vdc_pkg::ACC_W;

    // Coefficients in Q.FRAC_BITS, nearest with ties up
    localparam longint ONE_Q = longint'(1) << FRAC_BITS;

    localparam longint Q_VP4  = (251   * ONE_Q + 5000) / 10000;
    localparam longint Q_VP3  = (2683  * ONE_Q + 5000) / 10000;
    localparam longint Q_VP2  = (8206  * ONE_Q + 5000) / 10000;
    localparam longint Q_VP1  = (20947 * ONE_Q + 5000) / 10000;
    localparam longint Q_VP0  = (9409  * ONE_Q + 5000) / 10000;
    localparam longint Q_R1789 = (1789 * ONE_Q + 500) / 1000;
    localparam longint Q_R175  = (175  * ONE_Q + 50) / 100;
    localparam longint Q_LIN_A = (1373 * ONE_Q + 500) / 1000;
    localparam longint Q_LIN_B = (699  * ONE_Q + 500) / 1000;

    localparam longint Q_RHO4 = (1656   * ONE_Q + 50000) / 100000;
    localparam longint Q_RHO3 = (20673  * ONE_Q + 50000) / 100000;
    localparam longint Q_RHO2 = (83668  * ONE_Q + 50000) / 100000;
    localparam longint Q_RHO1 = (153201 * ONE_Q + 50000) / 100000;
    localparam longint Q_RHO0 = (122679 * ONE_Q + 50000) / 100000;
    localparam longint Q_RHO_BASE = (242 * ONE_Q + 50) / 100;

    localparam logic signed [ACC_W-1:0] VP_MAX_S  = ACC_W'(vdc_pkg::VP_MAX);
    localparam logic signed [ACC_W-1:0] RHO_MAX_S = ACC_W'(vdc_pkg::RHO_MAX);

    // Step coefficients, first step first
    localparam logic signed [ACC_W-1:0] VP_STEP_COEF [3] = '{
        ACC_W'(Q_VP3), ACC_W'(-Q_VP2), ACC_W'(Q_VP1)
    };
    localparam logic signed [ACC_W-1:0] RHO_STEP_COEF [4] = '{
        ACC_W'(Q_RHO3), ACC_W'(-Q_RHO2), ACC_W'(Q_RHO1), ACC_W'(Q_RHO0)
    };

    // ---- configuration registers ----
    logic [2:0]         vp_mode_reg;
    logic [1:0]         rho_mode_reg;
    logic [15:0]        vpvs_ratio_reg;
    logic signed [15:0] density_offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_mode_reg        <= vdc_pkg::VP_MODE_POLY;
            rho_mode_reg       <= 2'd1;
            vpvs_ratio_reg     <= 16'd7168;
            density_offset_reg <= 16'sd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                vdc_pkg::REG_VP_MODE:    vp_mode_reg        <= cfg_data[2:0];
                vdc_pkg::REG_RHO_MODE:   rho_mode_reg       <= cfg_data[1:0];
                vdc_pkg::REG_VPVS_RATIO: vpvs_ratio_reg     <= cfg_data;
                vdc_pkg::REG_DENS_OFS:   density_offset_reg <= $signed(cfg_data);
                default:                 vp_mode_reg        <= vp_mode_reg;
            endcase
        end
    end

    // ---- pipeline control ----
    // stage_valid[i+1] is the valid bit of step i; en[i] loads step i, en[4] the output
    logic [4:0]     stage_valid;
    logic [4:0]     en;
    logic           out_valid_reg;
    logic           vp_poly;
    vdc_pkg::lane_t lane [5];
    logic signed [ACC_W-1:0] vp_coef [4];

    assign stage_valid[0] = in_valid;
    assign in_stall       = !en[0];
    assign vp_poly        = (vp_mode_reg == vdc_pkg::VP_MODE_POLY);

    always_comb
    begin
        en[4] = !out_valid_reg || !out_stall;
        for (int i = 3; i >= 0; i--)
        begin
            en[i] = !stage_valid[i+1] || en[i+1];
        end
    end

    // Non-polynomial vp laws: seed the accumulator with the ratio/slope, skip
    // the first three steps, and let the last step do the single multiply.
    always_comb
    begin
        lane[0].vs  = shear_velocity;
        lane[0].rho = ACC_W'(-Q_RHO4);
        unique case (vp_mode_reg)
            vdc_pkg::VP_MODE_POLY:      lane[0].vp = ACC_W'(-Q_VP4);
            vdc_pkg::VP_MODE_RATIO_FIX: lane[0].vp = ACC_W'(Q_R1789);
            vdc_pkg::VP_MODE_RATIO_CFG: lane[0].vp = $signed(ACC_W'(vpvs_ratio_reg));
            vdc_pkg::VP_MODE_LINEAR:    lane[0].vp = ACC_W'(Q_LIN_A);
            default:                    lane[0].vp = ACC_W'(Q_R175);
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vp_coef[i] = VP_STEP_COEF[i];
        end
        if (vp_poly)
        begin
            vp_coef[3] = ACC_W'(Q_VP0);
        end
        else if (vp_mode_reg == vdc_pkg::VP_MODE_LINEAR)
        begin
            vp_coef[3] = ACC_W'(Q_LIN_B);
        end
        else
        begin
            vp_coef[3] = '0;
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_step
        vdc_horner_step #(
            .FRAC_BITS (FRAC_BITS)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en[g]),
            .valid_in  (stage_valid[g]),
            .lane_in   (lane[g]),
            .vp_coef   (vp_coef[g]),
            .rho_coef  (RHO_STEP_COEF[g]),
            .vp_mul_en ((g == 3) ? 1'b1 : vp_poly),
            .valid_out (stage_valid[g+1]),
            .lane_out  (lane[g+1])
        );
    end

    // ---- linear density side lane: 2.42 + (2*vs+4)/9 + offset ----
    logic [2*vdc_pkg::DIV9_X_W-1:0] lin_prod_reg;
    logic [vdc_pkg::DIV9_X_W-1:0]   div9_x;
    logic [vdc_pkg::DIV9_Q_W-1:0]   div9_q;
    logic signed [ACC_W-1:0]        lin_b_reg;
    logic signed [ACC_W-1:0]        lin_c_reg;
    logic signed [ACC_W-1:0]        lin_d_reg;

    assign div9_x = {1'b0, shear_velocity, 1'b0} + vdc_pkg::DIV9_X_W'(4);
    assign div9_q = lin_prod_reg[vdc_pkg::DIV9_SHIFT +: vdc_pkg::DIV9_Q_W];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lin_prod_reg <= (2*vdc_pkg::DIV9_X_W)'(div9_x)
                          * (2*vdc_pkg::DIV9_X_W)'(vdc_pkg::DIV9_RECIP);
        end
        if (en[1])
        begin
            lin_b_reg <= ACC_W'(Q_RHO_BASE) + $signed(ACC_W'(div9_q))
                       + ACC_W'(density_offset_reg);
        end
        if (en[2])
        begin
            lin_c_reg <= lin_b_reg;
        end
        if (en[3])
        begin
            lin_d_reg <= lin_c_reg;
        end
    end

    // ---- select, clamp, output register ----
    logic signed [ACC_W-1:0]     vp_fin;
    logic signed [ACC_W-1:0]     rho_fin;
    logic [vdc_pkg::VP_W-1:0]    vp_sat;
    logic [vdc_pkg::RHO_W-1:0]   rho_sat;
    logic [vdc_pkg::VP_W-1:0]    compressional_velocity_reg;
    logic [vdc_pkg::RHO_W-1:0]   density_reg;

    assign vp_fin  = lane[4].vp;
    assign rho_fin = (rho_mode_reg == vdc_pkg::RHO_MODE_LINEAR) ? lin_d_reg : lane[4].rho;

    always_comb
    begin
        if (vp_fin < 0)
        begin
            vp_sat = '0;
        end
        else if (vp_fin > VP_MAX_S)
        begin
            vp_sat = vdc_pkg::VP_W'(vdc_pkg::VP_MAX);
        end
        else
        begin
            vp_sat = vp_fin[vdc_pkg::VP_W-1:0];
        end

        if (rho_fin < 0)
        begin
            rho_sat = '0;
        end
        else if (rho_fin > RHO_MAX_S)
        begin
            rho_sat = vdc_pkg::RHO_W'(vdc_pkg::RHO_MAX);
        end
        else
        begin
            rho_sat = rho_fin[vdc_pkg::RHO_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en[4])
        begin
            out_valid_reg <= stage_valid[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            compressional_velocity_reg <= vp_sat;
            density_reg                <= rho_sat;
        end
    end

    assign out_valid              = out_valid_reg;
    assign compressional_velocity = compressional_velocity_reg;
    assign density                = density_reg;

    // ---- checks ----
    // input backs up only when every stage is full and the output is held
    `VDC_ASSERT_NOW(a_stall_only_when_full, in_stall,
        (&stage_valid[4:1]) && out_valid_reg && out_stall, "input stalled with room in pipe")
    // an accepted sample lands in the first step
    `VDC_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, stage_valid[1],
        "accepted sample lost at entry")
    // a finished sample moving out of the last step reaches the output
    `VDC_ASSERT_NEXT(a_last_to_out, stage_valid[4] && en[4], out_valid_reg,
        "sample lost before output")

endmodule

FILE: tb/velocity_density_converter_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// velocity_density_converter_unit_test
// Self-checking bench for the shear-to-compressional velocity and density
// converter. A directed table with a few hand-computed answers comes first.
// Then random samples are run under a series of register settings and
// flow-control patterns. Each transfer out is compared with its hand answer
// or with a fixed-point predictor kept in this file.
// ---------------------------------------------------------------------------
module velocity_density_converter_unit_test;

    localparam int FRAC = 12;

    // register values after reset
    localparam logic [15:0] VP_MODE_RESET  = 16'(vdc_pkg::VP_MODE_POLY);
    localparam logic [15:0] RHO_MODE_RESET = 16'd1;
    localparam logic [15:0] RATIO_RESET    = 16'd7168;   // 1.75 in Q4.12
    localparam logic [15:0] OFS_RESET      = 16'd0;

    localparam int N_DIRECTED    = 21;
    localparam int N_SEGMENTS    = 12;
    localparam int SEGMENT_ITEMS = 105;

    typedef struct packed {
        logic [vdc_pkg::VP_W-1:0]  vp;
        logic [vdc_pkg::RHO_W-1:0] rho;
    } result_t;

    // one directed row: raw register words, the sample, and an optional
    // hand-computed answer (typed = 1) that bypasses the predictor
    typedef struct packed {
        logic [15:0]               vm;
        logic [15:0]               rm;
        logic [15:0]               ratio;
        logic [15:0]               ofs;
        logic [15:0]               vs;
        logic                      typed;
        logic [vdc_pkg::VP_W-1:0]  vp;
        logic [vdc_pkg::RHO_W-1:0] rho;
    } vector_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [vdc_pkg::VS_W-1:0]   shear_velocity;
    logic                       out_valid;
    logic                       out_stall;
    logic [vdc_pkg::VP_W-1:0]   compressional_velocity;
    logic [vdc_pkg::RHO_W-1:0]  density;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [1:0]                 cfg_index;
    logic [15:0]                cfg_data;

    // predictor copy of the register file
    logic [2:0]         vp_mode_q;
    logic [1:0]         rho_mode_q;
    logic [15:0]        vpvs_ratio_q;
    logic signed [15:0] dens_ofs_q;
    // raw words last written, used to skip redundant writes
    logic [15:0]        reg_image [4];

    result_t pending_results [$];
    int      mismatch_count = 0;
    int      src_idle_pct   = 0;
    int      dst_stall_pct  = 0;

    // Directed table. Hand-computed answers: zero and full-scale input at the
    // reset modes, the fixed ratio mode at zero, the configured ratio saturating high,
    // the linear law at zero velocity (0.699), linear density with no offset
    // (2.42) and with the most negative offset (clamped at zero).
    // Rows 4 and 16 carry junk in the upper register bits to check masking.
    vector_t directed_vectors [N_DIRECTED] = '{
        '{16'd1,     16'd1,     16'd7168,  16'd0,     16'd0,     1'b1, 18'd3854,   16'd5025},
        '{16'd1,     16'd1,     16'd7168,  16'd0,     16'd65535, 1'b1, 18'd0,      16'd0},
        '{16'd1,     16'd1,     16'd7168,  16'd0,     16'd4096,  1'b0, 18'd0,      16'd0},
        '{16'd1,     16'd1,     16'd7168,  16'd0,     16'd14336, 1'b0, 18'd0,      16'd0},
        '{16'hFFF9,  16'd1,     16'd7168,  16'd0,     16'd20480, 1'b0, 18'd0,      16'd0},
        '{16'd2,     16'd1,     16'd7168,  16'd0,     16'd0,     1'b1, 18'd0,      16'd5025},
        '{16'd2,     16'd1,     16'd7168,  16'd0,     16'd65535, 1'b0, 18'd0,      16'd0},
        '{16'd3,     16'd1,     16'd65535, 16'd0,     16'd65535, 1'b1, 18'd262143, 16'd0},
        '{16'd3,     16'd1,     16'd0,     16'd0,     16'd40000, 1'b0, 18'd0,      16'd0},
        '{16'd4,     16'd1,     16'd7168,  16'd0,     16'd0,     1'b1, 18'd2863,   16'd5025},
        '{16'd4,     16'd1,     16'd7168,  16'd0,     16'd65535, 1'b0, 18'd0,      16'd0},
        '{16'd0,     16'd1,     16'd7168,  16'd0,     16'd12345, 1'b0, 18'd0,      16'd0},
        '{16'd5,     16'd1,     16'd7168,  16'd0,     16'h5555,  1'b0, 18'd0,      16'd0},
        '{16'd6,     16'd1,     16'd7168,  16'd0,     16'hAAAA,  1'b0, 18'd0,      16'd0},
        '{16'd7,     16'd1,     16'd7168,  16'd0,     16'hFFFF,  1'b0, 18'd0,      16'd0},
        '{16'd4,     16'd2,     16'd7168,  16'd0,     16'd0,     1'b1, 18'd2863,   16'd9912},
        '{16'd4,     16'hFFFE,  16'd7168,  16'h8000,  16'd0,     1'b1, 18'd2863,   16'd0},
        '{16'd4,     16'd2,     16'd7168,  16'h7FFF,  16'd65535, 1'b0, 18'd0,      16'd0},
        '{16'd4,     16'd0,     16'd7168,  16'd0,     16'd8192,  1'b0, 18'd0,      16'd0},
        '{16'd4,     16'd3,     16'd7168,  16'd0,     16'd8192,  1'b0, 18'd0,      16'd0},
        '{16'd3,     16'd1,     16'h1CCD,  16'd0,     16'd12288, 1'b0, 18'd0,      16'd0}
    };

    velocity_density_converter_unit #(
        .FRAC_BITS (FRAC)
    ) DUT (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .in_valid               (in_valid),
        .in_stall               (in_stall),
        .shear_velocity         (shear_velocity),
        .out_valid              (out_valid),
        .out_stall              (out_stall),
        .compressional_velocity (compressional_velocity),
        .density                (density),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data)
    );

    always #1 clk = ~clk;

    // -----------------------------------------------------------------------
    // Fixed-point predictor
    // -----------------------------------------------------------------------

    // coefficient num/den in Q.FRAC, nearest, ties up
    function automatic longint fix_coef(input longint num, input longint den);
        return (num * (longint'(1) << FRAC) + den / 2) / den;
    endfunction

    // Q.FRAC product, nearest, ties away from zero
    function automatic longint round_mul(input longint a, input longint b);
        longint p;
        longint half;
        p    = a * b;
        half = longint'(1) << (FRAC - 1);
        if (p >= 0)
            return (p + half) >>> FRAC;
        return -((-p + half) >>> FRAC);
    endfunction

    function automatic longint clamp_to(input longint x, input longint hi);
        if (x < 0)
            return 0;
        if (x > hi)
            return hi;
        return x;
    endfunction

    function automatic result_t convert_sample(input logic [vdc_pkg::VS_W-1:0] vs);
        longint  v;
        longint  vp;
        longint  rho;
        result_t r;
        v = longint'(vs);
        case (vp_mode_q)
            vdc_pkg::VP_MODE_POLY:
            begin
                // Horner, highest power first
                vp = -fix_coef(251, 10000);
                vp = round_mul(vp, v) + fix_coef(2683, 10000);
                vp = round_mul(vp, v) - fix_coef(8206, 10000);
                vp = round_mul(vp, v) + fix_coef(20947, 10000);
                vp = round_mul(vp, v) + fix_coef(9409, 10000);
            end
            vdc_pkg::VP_MODE_RATIO_FIX: vp = round_mul(v, fix_coef(1789, 1000));
            vdc_pkg::VP_MODE_RATIO_CFG: vp = round_mul(v, longint'(vpvs_ratio_q));
            vdc_pkg::VP_MODE_LINEAR:
                vp = round_mul(v, fix_coef(1373, 1000)) + fix_coef(699, 1000);
            default:                    vp = round_mul(v, fix_coef(175, 100));
        endcase
        if (rho_mode_q == vdc_pkg::RHO_MODE_LINEAR)
        begin
            // vs / 4.5 as (2*vs + 4) / 9, rounds to nearest
            rho = fix_coef(242, 100) + (2 * v + 4) / 9 + longint'(dens_ofs_q);
        end
        else
        begin
            rho = -fix_coef(1656, 100000);
            rho = round_mul(rho, v) + fix_coef(20673, 100000);
            rho = round_mul(rho, v) - fix_coef(83668, 100000);
            rho = round_mul(rho, v) + fix_coef(153201, 100000);
            rho = round_mul(rho, v) + fix_coef(122679, 100000);
        end
        r.vp  = vdc_pkg::VP_W'(clamp_to(vp, longint'(vdc_pkg::VP_MAX)));
        r.rho = vdc_pkg::RHO_W'(clamp_to(rho, longint'(vdc_pkg::RHO_MAX)));
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Drivers
    // -----------------------------------------------------------------------

    // One register write; cfg_ready is honored even though the block ties it.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        // transfer done: mirror it, keeping only the register's width
        reg_image[idx] = data;
        case (idx)
            vdc_pkg::REG_VP_MODE:    vp_mode_q    = data[2:0];
            vdc_pkg::REG_RHO_MODE:   rho_mode_q   = data[1:0];
            vdc_pkg::REG_VPVS_RATIO: vpvs_ratio_q = data;
            vdc_pkg::REG_DENS_OFS:   dens_ofs_q   = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Move to new register settings. Writes happen only with the pipe empty:
    // input held off, every pending result drained, then a short settle.
    task automatic load_settings(input logic [15:0] vm, input logic [15:0] rm,
                                 input logic [15:0] ratio, input logic [15:0] ofs);
        if (vm !== reg_image[vdc_pkg::REG_VP_MODE] ||
            rm !== reg_image[vdc_pkg::REG_RHO_MODE] ||
            ratio !== reg_image[vdc_pkg::REG_VPVS_RATIO] ||
            ofs !== reg_image[vdc_pkg::REG_DENS_OFS])
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
            if (vm !== reg_image[vdc_pkg::REG_VP_MODE])
                write_reg(vdc_pkg::REG_VP_MODE, vm);
            if (rm !== reg_image[vdc_pkg::REG_RHO_MODE])
                write_reg(vdc_pkg::REG_RHO_MODE, rm);
            if (ratio !== reg_image[vdc_pkg::REG_VPVS_RATIO])
                write_reg(vdc_pkg::REG_VPVS_RATIO, ratio);
            if (ofs !== reg_image[vdc_pkg::REG_DENS_OFS])
                write_reg(vdc_pkg::REG_DENS_OFS, ofs);
        end
    endtask

    // One sample transfer, with random idle cycles ahead of it. in_valid stays
    // high afterwards so back-to-back transfers need no extra step.
    task automatic send_sample(input logic [vdc_pkg::VS_W-1:0] vs, input logic typed,
                               input result_t hand_result);
        result_t expected;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        shear_velocity <= vs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected        = typed ? hand_result : convert_sample(vs);
        pending_results = {pending_results, expected};
    endtask

    // Sample mix: full range, the geologic range (0..8 km/s), and the ends.
    function automatic logic [vdc_pkg::VS_W-1:0] pick_velocity();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return vdc_pkg::VS_W'($urandom);
        if (pick < 8)
            return vdc_pkg::VS_W'($urandom_range(0, 32767));
        if (pick == 8)
            return vdc_pkg::VS_W'($urandom_range(0, 15));
        return vdc_pkg::VS_W'(16'hFFFF - $urandom_range(0, 15));
    endfunction

    // Receiver: stall decided fresh every cycle, independent of out_valid.
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < dst_stall_pct);

    // -----------------------------------------------------------------------
    // Checker: every output transfer against the oldest expectation
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: compressional_velocity %0d, density %0d",
                       compressional_velocity, density);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (compressional_velocity !== want.vp)
                begin
                    $error("compressional_velocity: expected %0d, got %0d",
                           want.vp, compressional_velocity);
                    mismatch_count++;
                end
                if (density !== want.rho)
                begin
                    $error("density: expected %0d, got %0d", want.rho, density);
                    mismatch_count++;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial
    begin
        result_t     hand_result;
        logic [15:0] vm_word;
        logic [15:0] rm_word;
        logic [15:0] ratio_word;
        logic [15:0] ofs_word;

        // all inputs known from time zero
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        shear_velocity = '0;
        out_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = vdc_pkg::REG_VP_MODE;
        cfg_data       = '0;

        vp_mode_q                          = VP_MODE_RESET[2:0];
        rho_mode_q                         = RHO_MODE_RESET[1:0];
        vpvs_ratio_q                       = RATIO_RESET;
        dens_ofs_q                         = OFS_RESET;
        reg_image[vdc_pkg::REG_VP_MODE]    = VP_MODE_RESET;
        reg_image[vdc_pkg::REG_RHO_MODE]   = RHO_MODE_RESET;
        reg_image[vdc_pkg::REG_VPVS_RATIO] = RATIO_RESET;
        reg_image[vdc_pkg::REG_DENS_OFS]   = OFS_RESET;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table, under light source idling and heavy back-pressure;
        // the first rows run on reset values, so no write precedes them
        src_idle_pct  = 18;
        dst_stall_pct = 63;
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            load_settings(directed_vectors[i].vm, directed_vectors[i].rm,
                          directed_vectors[i].ratio, directed_vectors[i].ofs);
            hand_result.vp  = directed_vectors[i].vp;
            hand_result.rho = directed_vectors[i].rho;
            send_sample(directed_vectors[i].vs, directed_vectors[i].typed, hand_result);
        end

        // Random segments. Low mode bits step through every code, the upper
        // bits are junk. Ratio and offset hit their extremes in two of every 4 segments.
        // Flow control: segments 0-3 back-pressure heavy, 4-7 source sparse,
        // 8-11 no idling at all.
        for (int seg = 0; seg < N_SEGMENTS; seg++)
        begin
            if (seg < 4)
            begin
                src_idle_pct  = 18;
                dst_stall_pct = 63;
            end
            else if (seg < 8)
            begin
                src_idle_pct  = 63;
                dst_stall_pct = 18;
            end
            else
            begin
                src_idle_pct  = 0;
                dst_stall_pct = 0;
            end

            vm_word      = 16'($urandom);
            vm_word[2:0] = seg[2:0];
            rm_word      = 16'($urandom);
            rm_word[1:0] = seg[3:2] ^ seg[1:0];
            case (seg % 4)
                0:
                begin
                    ratio_word = 16'h0000;
                    ofs_word   = 16'h8000;
                end
                1:
                begin
                    ratio_word = 16'hFFFF;
                    ofs_word   = 16'h7FFF;
                end
                2:
                begin
                    ratio_word = 16'($urandom);
                    ofs_word   = 16'h0000;
                end
                default:
                begin
                    ratio_word = 16'($urandom);
                    ofs_word   = 16'($urandom);
                end
            endcase
            load_settings(vm_word, rm_word, ratio_word, ofs_word);

            for (int n = 0; n < SEGMENT_ITEMS; n++)
                send_sample(pick_velocity(), 1'b0, hand_result);
        end

        // drain, then give the pipe time to show any stray transfer
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (mismatch_count == 0)
            $display("velocity_density_converter_unit regression: pass");
        else
            $display("velocity_density_converter_unit regression: fail");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #400_000;
        $display("velocity_density_converter_unit regression: fail");
        $finish;
    end

endmodule

FILE: velocity_density_converter_unit.f
+incdir+rtl
rtl/vdc_pkg.sv
rtl/vdc_horner_step.sv
rtl/velocity_density_converter_unit.sv
tb/velocity_density_converter_unit_test.sv
